// File: rtl/kda_pkg.sv
// Shared types and constants for the keypad debounce / auto-repeat block.
package kda_pkg;

    localparam int KEY_LINES_W = 9;
    localparam int CODE_W      = 4;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int HOLD_W      = 9;
    localparam int CLICK_W     = 8;

    // Counter jump past the threshold when a key latches.
    localparam logic [HOLD_W-1:0]  LATCH_JUMP     = 9'd10;
    // Step limit for a held key while repeat is not armed.
    localparam logic [CFG_W-1:0]   UNARMED_STEP   = 8'd5;
    localparam logic [CLICK_W-1:0] CLICK_MAX      = 8'd255;
    localparam logic [CODE_W-1:0]  NO_KEY         = 4'd0;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 8'd10;
    localparam logic [CFG_W-1:0] CLICKS_RST   = 8'd5;
    localparam logic [CFG_W-1:0] SLOW_RST     = 8'd100;
    localparam logic [CFG_W-1:0] FAST_RST     = 8'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_TICKS     = 8'd0,
        REG_CLICKS_BEFORE_FAST = 8'd1,
        REG_SLOW_INTERVAL      = 8'd2,
        REG_FAST_INTERVAL      = 8'd3
    } cfg_reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] clicks_before_fast;
        logic [CFG_W-1:0] slow_interval;
        logic [CFG_W-1:0] fast_interval;
    } kda_cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              key_taken;
    } kda_result_t;

endpackage

// File: rtl/keypad_debounce_autorepeat.sv
// Top level: keypad debounce with auto-repeat, stream in / stream out.
// Usage:
//   s_axis carries one scan tick per beat. The block answers every input
//   beat with exactly one m_axis beat holding the latched key after that
//   scan and a flag telling whether this tick's read consumed a key.
//   The cfg channel writes the four timing registers (index 0..3: debounce
//   ticks, clicks before fast, slow interval, fast interval); other indexes
//   are dropped. cfg_ready is always high; write only while idle.
// Path: a beat accepted on s_axis passes the input register, then one pass
//   of key pick + scan update into the output register, from which it shows
//   up on m_axis.
// Throughput: one beat per cycle while m_axis_tready is high; the update
//   is a handful of 9-bit compares and increments between the two registers.
// Reset: rst_n (async, active low) clears the hold counter, clicks, arm
//   flag and latched key, sets the repeat gap to 100 and the registers to
//   10 / 5 / 100 / 20. Both pipeline stages come up empty.
// Stall: when m_axis_tready is low the result holds in the output register;
//   the input register still takes one more beat, after which s_axis_tready
//   drops until the output drains.
module keypad_debounce_autorepeat #(
    parameter int NUM_ROWS = 3,
    parameter int NUM_COLS = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input beat: [8:0] key_lines, [9] arm_repeat, [10] take_key, rest zero
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,
    // Result beat: [3:0] key_code, [4] key_taken, rest zero
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,
    // Register write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kda_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kda_pkg::CFG_W-1:0]       cfg_data
);
    import kda_pkg::*;

    // Config registers
    kda_cfg_t cfg_reg;

    // Input stage
    logic                   in_valid_reg;
    logic [KEY_LINES_W-1:0] lines_reg;
    logic                   arm_reg;
    logic                   take_reg;

    // Output stage
    logic              out_valid_reg;
    kda_result_t       out_reg;

    logic              out_free;
    logic              s_fire;
    logic              advance;
    logic [CODE_W-1:0] picked;
    kda_result_t       result;

    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign advance       = in_valid_reg && out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.key_taken, out_reg.key_code};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks     <= DEBOUNCE_RST;
            cfg_reg.clicks_before_fast <= CLICKS_RST;
            cfg_reg.slow_interval      <= SLOW_RST;
            cfg_reg.fast_interval      <= FAST_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_TICKS:     cfg_reg.debounce_ticks     <= cfg_data;
                REG_CLICKS_BEFORE_FAST: cfg_reg.clicks_before_fast <= cfg_data;
                REG_SLOW_INTERVAL:      cfg_reg.slow_interval      <= cfg_data;
                REG_FAST_INTERVAL:      cfg_reg.fast_interval      <= cfg_data;
                default: ;  // unknown index: dropped
            endcase
        end
    end

    // Input register: loads on accept, empties when the result slot frees.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            lines_reg <= s_axis_tdata[KEY_LINES_W-1:0];
            arm_reg   <= s_axis_tdata[KEY_LINES_W];
            take_reg  <= s_axis_tdata[KEY_LINES_W+1];
        end
    end

    kda_key_pick #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    ) u_pick (
        .key_lines (lines_reg),
        .key_code  (picked)
    );

    // State advances exactly once per beat, as it moves to the output stage.
    kda_scan_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (advance),
        .key_code   (picked),
        .arm_repeat (arm_reg),
        .take_key   (take_reg),
        .cfg        (cfg_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

endmodule

// File: rtl/kda_key_pick.sv
// Key selection: highest pressed row, lowest pressed column within it.
module kda_key_pick #(
    parameter int NUM_ROWS = 3,
    parameter int NUM_COLS = 3
) (
    input  logic [kda_pkg::KEY_LINES_W-1:0] key_lines,
    output logic [kda_pkg::CODE_W-1:0]      key_code
);
    import kda_pkg::*;

    localparam int EXT_W = 64;

    logic [EXT_W-1:0] lines_ext;

    assign lines_ext = EXT_W'(key_lines);

    // Later rows override earlier ones; first hit inside a row wins.
    always_comb
    begin
        logic row_hit;
        int   bit_idx;
        key_code = NO_KEY;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row_hit = 1'b0;
            for (int c = 0; c < NUM_COLS; c++)
            begin
                bit_idx = r * NUM_COLS + c;
                if (!row_hit && (bit_idx < KEY_LINES_W) && lines_ext[bit_idx[5:0]])
                begin
                    key_code = CODE_W'(bit_idx + 1);
                    row_hit  = 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/kda_scan_core.sv
// Debounce / auto-repeat state and its per-tick update.
module kda_scan_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tick,
    input  logic [kda_pkg::CODE_W-1:0] key_code,
    input  logic                       arm_repeat,
    input  logic                       take_key,
    input  kda_pkg::kda_cfg_t          cfg,
    output kda_pkg::kda_result_t       result
);
    import kda_pkg::*;

    logic [HOLD_W-1:0]  hold_reg,    hold_next;
    logic [CLICK_W-1:0] clicks_reg,  clicks_next;
    logic               armed_reg,   armed_next;
    logic [CFG_W-1:0]   gap_reg,     gap_next;
    logic [CODE_W-1:0]  latched_reg, latched_next;

    logic               armed_eff;
    logic [CFG_W-1:0]   step;
    logic [HOLD_W-1:0]  db_ext;
    logic [HOLD_W-1:0]  step_limit;
    logic [HOLD_W-1:0]  gap_limit;
    logic [CODE_W-1:0]  shown;

    assign armed_eff = armed_reg | arm_repeat;
    assign db_ext    = HOLD_W'(cfg.debounce_ticks);

    always_comb
    begin
        hold_next   = hold_reg;
        clicks_next = clicks_reg;
        armed_next  = armed_eff;
        gap_next    = gap_reg;
        shown       = latched_reg;
        step        = UNARMED_STEP;

        if (armed_eff)
        begin
            step     = (clicks_reg < cfg.clicks_before_fast) ? cfg.slow_interval
                                                             : cfg.fast_interval;
            gap_next = step;
        end
        // Max 255 + 255, fits the 9-bit counter.
        step_limit = db_ext + HOLD_W'(step);
        gap_limit  = db_ext + HOLD_W'(gap_next);

        if (key_code == NO_KEY)
        begin
            armed_next  = 1'b0;
            hold_next   = '0;
            clicks_next = '0;
            gap_next    = gap_reg;
        end
        else
        begin
            priority if (hold_reg == db_ext)
            begin
                hold_next = db_ext + LATCH_JUMP;
                shown     = key_code;
            end
            else if (hold_reg < step_limit)
            begin
                hold_next = hold_reg + 1'b1;
            end
            else if (hold_reg >= gap_limit)
            begin
                hold_next = '0;
                if (clicks_reg != CLICK_MAX)
                begin
                    clicks_next = clicks_reg + 1'b1;
                end
            end
            else
            begin
                hold_next = hold_reg;  // parked between step and gap limits
            end
        end

        latched_next     = take_key ? NO_KEY : shown;
        result.key_code  = shown;
        result.key_taken = take_key && (shown != NO_KEY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg    <= '0;
            clicks_reg  <= '0;
            armed_reg   <= 1'b0;
            gap_reg     <= SLOW_RST;
            latched_reg <= NO_KEY;
        end
        else if (tick)
        begin
            hold_reg    <= hold_next;
            clicks_reg  <= clicks_next;
            armed_reg   <= armed_next;
            gap_reg     <= gap_next;
            latched_reg <= latched_next;
        end
    end

endmodule
